/* rtl/core/rtvd_pkg.sv */
package rtvd_pkg;

	// shared unit widths: magnitude operand, multiplier operand, product
	localparam int AW = 52;
	localparam int BW = 47;
	localparam int PW = AW + BW;
	localparam int MW = PW + 1;

	typedef enum logic {
		OP_MUL    = 1'b0,
		OP_MULDIV = 1'b1
	} arith_op_t;

	typedef struct packed {
		arith_op_t       op;
		logic            neg;
		logic [AW-1:0]   a;
		logic [BW-1:0]   b;
		logic [BW-1:0]   d;
	} arith_req_t;

	// result passes per cell: two cells back, one cell back, this cell
	typedef enum logic [1:0] {
		PASS_LAG2 = 2'd0,
		PASS_LAG1 = 2'd1,
		PASS_CUR  = 2'd2
	} pass_t;

	localparam logic [47:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] NEG_LIM = 48'h8000_0000_0000;

	// clamp a magnitude to 48-bit signed range and apply the sign
	function automatic logic [47:0] sat_mag(input logic neg, input logic [MW-1:0] m);
		logic [MW-1:0] lim;
		logic [47:0]   v;
		lim = neg ? MW'(NEG_LIM) : MW'(POS_LIM);
		v = (m > lim) ? lim[47:0] : m[47:0];
		return neg ? (48'd0 - v) : v;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [AW-1:0] x);
		if (x > $signed(AW'(POS_LIM)))
			return $signed(POS_LIM);
		if (x < -$signed(AW'(NEG_LIM)))
			return $signed(NEG_LIM);
		return x[47:0];
	endfunction

	// halve, truncating toward zero
	function automatic logic signed [AW-1:0] half_tz(input logic signed [AW-1:0] x);
		logic signed [AW-1:0] t;
		t = x + AW'(x[AW-1]);
		return t >>> 1;
	endfunction

	function automatic logic signed [AW-1:0] minmod(input logic signed [AW-1:0] a,
		input logic signed [AW-1:0] b);
		if (a > 0 && b > 0)
			return (a < b) ? a : b;
		if (a < 0 && b < 0)
			return (a > b) ? a : b;
		return '0;
	endfunction

	function automatic logic [AW-1:0] mag(input logic signed [AW-1:0] x);
		return x[AW-1] ? AW'(-x) : AW'(x);
	endfunction

endpackage

/* rtl/core/relaxing_tvd_minmod_stencil_top.sv */
// Relaxing TVD stencil with minmod limiter, streamed over one 1D grid.
// Input channel: one request per cell (value, flux, source, speed, spacing,
// last_cell); accepted when in_valid is high and in_stall low. The block
// stalls its input while it works on a cell.
// Output channel: new_value, cell_index, end_of_grid; a result is taken when
// out_valid is high and out_stall low. The result for cell i appears while
// cell i+2 is processed; a last cell also flushes the two pending cells.
// Work per cell, sequenced around one shared bit-serial multiply/divide unit:
//   speed product and flux halving, then per result pass a pass-through
//   (first cell, last cell), an interior update (multiply-divide, source
//   product, control steps) or nothing when the pass emits nothing, then
//   the update. Receiver stalls lengthen the work on a cell.
// A stalled receiver holds the single output register; the block waits
// before loading the next result and keeps its input stalled meanwhile.
// Reset clears the cell counter and the control state and sets time_step to
// 1.0; the cell windows need no clearing. time_step is written over the
// APB-style port at address 0; the user must write it only while the block
// is idle, since the block itself does not enforce this.
module relaxing_tvd_minmod_stencil_top import rtvd_pkg::*; #(
	parameter int MAX_CELLS = 1024,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [47:0] cell_value,
	input  logic signed [47:0] cell_flux,
	input  logic signed [47:0] cell_source,
	input  logic [46:0]        freeze_speed,
	input  logic [46:0]        spacing_back,
	input  logic               last_cell,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [47:0] new_value,
	output logic [9:0]         cell_index,
	output logic               end_of_grid
);

	localparam int CW = $clog2(MAX_CELLS);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_CU   = 11'b000_0000_0010,
		ST_FLUX = 11'b000_0000_0100,
		ST_PASS = 11'b000_0000_1000,
		ST_DIFF = 11'b000_0001_0000,
		ST_DIVS = 11'b000_0010_0000,
		ST_DIV  = 11'b000_0100_0000,
		ST_SRC  = 11'b000_1000_0000,
		ST_SUM  = 11'b001_0000_0000,
		ST_EMIT = 11'b010_0000_0000,
		ST_UPD  = 11'b100_0000_0000
	} state_t;

	state_t st_q;

	logic [31:0] time_step_q;

	logic signed [47:0] u_q, f_q, s_q;
	logic [46:0]        sp_q;
	logic               last_q;
	logic [CW-1:0]      j_q, cnt_q;
	pass_t              pass_q;

	logic signed [47:0] cu_q, fr_q, fl_q;
	logic signed [47:0] rw_q [4];
	logic signed [47:0] lw_q [4];
	logic signed [47:0] vd_q [3];
	logic signed [47:0] sd_q [3];
	logic [46:0]        pd_q [3];

	logic signed [AW-1:0] diff_q;
	logic signed [47:0]   term_q, src_q, ov_q;
	logic [CW-1:0]        oidx_q;
	logic                 oend_q;

	logic               out_valid_q;
	logic signed [47:0] new_value_q;
	logic [9:0]         cell_index_q;
	logic               end_q;

	arith_req_t  au_req_q;
	logic        au_start_q;
	logic        au_done;
	logic [47:0] au_res;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? time_step_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			time_step_q <= 32'd65536;
		else if (psel && penable && pwrite && paddr == 3'd0)
			time_step_q <= pwdata;
	end

	rtvd_arith #(.FRACTION_BITS(FRACTION_BITS)) u_arith (
		.clk   (clk),
		.arst_n(arst_n),
		.start (au_start_q),
		.req   (au_req_q),
		.done  (au_done),
		.res   (au_res)
	);

	// per-pass selection of the cell and its stencil
	logic                 pass_ok, pass_thru, back_ok, fwd_ok;
	logic [CW-1:0]        pass_i;
	logic signed [47:0]   v_sel, s_sel;
	logic [46:0]          sp_sel;
	logic signed [AW-1:0] r0, r1, r2, r3, l0, l1, l2, l3;
	logic signed [AW-1:0] frp, frm, flp, flm, diff_c;
	logic signed [AW-1:0] sum_c;

	always_comb begin
		pass_ok = 1'b0;
		pass_i = j_q;
		v_sel = u_q;
		s_sel = s_q;
		sp_sel = sp_q;
		r0 = AW'(rw_q[3]); r1 = AW'(rw_q[2]); r2 = AW'(rw_q[1]); r3 = AW'(rw_q[0]);
		l0 = AW'(lw_q[2]); l1 = AW'(lw_q[1]); l2 = AW'(lw_q[0]); l3 = AW'(fl_q);
		unique case (pass_q)
			PASS_LAG2: begin
				pass_ok = (j_q >= CW'(2));
				pass_i = j_q - CW'(2);
				v_sel = vd_q[1];
				s_sel = sd_q[1];
				sp_sel = pd_q[1];
			end
			PASS_LAG1: begin
				pass_ok = last_q && (j_q >= CW'(1));
				pass_i = j_q - CW'(1);
				v_sel = vd_q[0];
				s_sel = sd_q[0];
				sp_sel = pd_q[0];
				r0 = AW'(rw_q[2]); r1 = AW'(rw_q[1]); r2 = AW'(rw_q[0]); r3 = AW'(fr_q);
				l0 = AW'(lw_q[1]); l1 = AW'(lw_q[0]); l2 = AW'(fl_q); l3 = '0;
			end
			PASS_CUR: pass_ok = last_q;
			default: pass_ok = 1'b0;
		endcase
		pass_thru = (pass_q == PASS_CUR) || (pass_i == '0);
		back_ok = (pass_i >= CW'(2));
		fwd_ok = (pass_q == PASS_LAG2);

		// limited fluxes at both faces
		frp = r2 + half_tz(minmod(r2 - r1, r3 - r2));
		flm = l1 + half_tz(minmod(l0 - l1, l1 - l2));
		frm = r1 + (back_ok ? half_tz(minmod(r1 - r0, r2 - r1)) : '0);
		flp = l2 + (fwd_ok ? half_tz(minmod(l1 - l2, l2 - l3)) : '0);
		diff_c = (frp - flp) - (frm - flm);

		sum_c = AW'(v_sel) - AW'(term_q) + AW'(src_q);
	end

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	logic out_load;
	assign out_load = (st_q == ST_EMIT) && out_free;

	// output valid: set on load, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	logic signed [AW-1:0] fsum_p, fsum_m;
	assign fsum_p = AW'(cu_q) + AW'(f_q);
	assign fsum_m = AW'(cu_q) - AW'(f_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			pass_q <= PASS_LAG2;
			au_start_q <= 1'b0;
		end else begin
			au_start_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						u_q <= cell_value;
						f_q <= cell_flux;
						s_q <= cell_source;
						sp_q <= spacing_back;
						j_q <= cnt_q;
						last_q <= last_cell || (cnt_q >= CW'(MAX_CELLS - 1));
						au_req_q <= '{op: OP_MUL, neg: cell_value[47],
							a: mag(AW'(cell_value)), b: freeze_speed, d: '0};
						au_start_q <= 1'b1;
						st_q <= ST_CU;
					end
				end
				ST_CU: begin
					if (au_done) begin
						cu_q <= au_res;
						st_q <= ST_FLUX;
					end
				end
				ST_FLUX: begin
					fr_q <= 48'(half_tz(fsum_p));
					fl_q <= 48'(half_tz(fsum_m));
					pass_q <= PASS_LAG2;
					st_q <= ST_PASS;
				end
				ST_PASS: begin
					oidx_q <= pass_i;
					oend_q <= (pass_q == PASS_CUR);
					ov_q <= v_sel;
					priority if (!pass_ok) begin
						if (pass_q == PASS_CUR)
							st_q <= ST_UPD;
						else
							pass_q <= pass_t'(pass_q + 2'd1);
					end else if (pass_thru) begin
						st_q <= ST_EMIT;
					end else begin
						st_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					diff_q <= diff_c;
					st_q <= ST_DIVS;
				end
				ST_DIVS: begin
					au_req_q <= '{op: OP_MULDIV, neg: diff_q[AW-1], a: mag(diff_q),
						b: BW'(time_step_q), d: (sp_sel == '0) ? BW'(1) : sp_sel};
					au_start_q <= 1'b1;
					st_q <= ST_DIV;
				end
				ST_DIV: begin
					if (au_done) begin
						term_q <= au_res;
						au_req_q <= '{op: OP_MUL, neg: s_sel[47], a: mag(AW'(s_sel)),
							b: BW'(time_step_q), d: '0};
						au_start_q <= 1'b1;
						st_q <= ST_SRC;
					end
				end
				ST_SRC: begin
					if (au_done) begin
						src_q <= au_res;
						st_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					ov_q <= sat48(sum_c);
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						new_value_q <= ov_q;
						cell_index_q <= 10'(oidx_q);
						end_q <= oend_q;
						if (pass_q == PASS_CUR) begin
							st_q <= ST_UPD;
						end else begin
							pass_q <= pass_t'(pass_q + 2'd1);
							st_q <= ST_PASS;
						end
					end
				end
				ST_UPD: begin
					cnt_q <= last_q ? '0 : j_q + CW'(1);
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// cell windows, shifted once per cell
	always_ff @(posedge clk) begin
		if (st_q == ST_UPD) begin
			for (int k = 3; k > 0; k--) begin
				rw_q[k] <= rw_q[k-1];
				lw_q[k] <= lw_q[k-1];
			end
			rw_q[0] <= fr_q;
			lw_q[0] <= fl_q;
			for (int k = 2; k > 0; k--) begin
				vd_q[k] <= vd_q[k-1];
				sd_q[k] <= sd_q[k-1];
				pd_q[k] <= pd_q[k-1];
			end
			vd_q[0] <= u_q;
			sd_q[0] <= s_q;
			pd_q[0] <= sp_q;
		end
	end

	assign in_stall = (st_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign new_value = new_value_q;
	assign cell_index = cell_index_q;
	assign end_of_grid = end_q;

	// a taken request keeps the input stalled on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// the shared unit only finishes while the sequencer waits for it
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		au_done |-> (st_q == ST_CU || st_q == ST_DIV || st_q == ST_SRC))
		else $error("arith result with no waiting state");

	// cell counter stays within the grid
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_CELLS - 1))
		else $error("cell counter out of range");

endmodule

/* rtl/core/rtvd_arith.sv */
module rtvd_arith import rtvd_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  arith_req_t  req,
	output logic        done,
	output logic [47:0] res
);

	localparam int RS = (FRACTION_BITS > 0) ? FRACTION_BITS - 1 : 0;
	localparam logic [MW-1:0] RND = (FRACTION_BITS > 0) ? (MW'(1) << RS) : '0;

	typedef enum logic [3:0] {
		A_IDLE = 4'b0001,
		A_MUL  = 4'b0010,
		A_DIV  = 4'b0100,
		A_FIN  = 4'b1000
	} arith_state_t;

	arith_state_t st_q;
	arith_req_t   req_q;
	logic [6:0]    cnt_q;
	logic [PW-1:0] acc_q;
	logic [PW-1:0] quo_q;
	logic [47:0]   rem_q;
	logic [47:0]   res_q;
	logic          done_q;

	logic [47:0]   r2;
	logic [MW-1:0] m;

	// restoring divider step and final rounding
	always_comb begin
		r2 = {rem_q[46:0], acc_q[cnt_q]};
		if (req_q.op == OP_MUL)
			m = (MW'(acc_q) + RND) >> FRACTION_BITS;
		else
			m = MW'(quo_q) + MW'({rem_q, 1'b0} >= 49'(req_q.d));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= A_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				A_IDLE: begin
					if (start) begin
						req_q <= req;
						acc_q <= '0;
						quo_q <= '0;
						rem_q <= '0;
						cnt_q <= 7'(BW - 1);
						st_q <= A_MUL;
					end
				end
				// shift-add multiply, msb of b first
				A_MUL: begin
					acc_q <= {acc_q[PW-2:0], 1'b0} +
						(req_q.b[cnt_q[5:0]] ? PW'(req_q.a) : '0);
					if (cnt_q == '0) begin
						cnt_q <= 7'(PW - 1);
						st_q <= (req_q.op == OP_MUL) ? A_FIN : A_DIV;
					end else begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				// one quotient bit per cycle
				A_DIV: begin
					if (r2 >= 48'(req_q.d)) begin
						rem_q <= r2 - 48'(req_q.d);
						quo_q <= {quo_q[PW-2:0], 1'b1};
					end else begin
						rem_q <= r2;
						quo_q <= {quo_q[PW-2:0], 1'b0};
					end
					if (cnt_q == '0)
						st_q <= A_FIN;
					else
						cnt_q <= cnt_q - 7'd1;
				end
				A_FIN: begin
					res_q <= sat_mag(req_q.neg, m);
					done_q <= 1'b1;
					st_q <= A_IDLE;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

/* bench/relaxing_tvd_minmod_stencil_checker.sv */
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts each cell update
// and compares the results in order.
module relaxing_tvd_minmod_stencil_checker #(
	parameter int MAX_CELLS = 1024,
	parameter int FRACTION_BITS = 16,
	parameter logic [2:0] TIME_STEP_ADDR = 3'd0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [47:0] cell_value,
	input  logic signed [47:0] cell_flux,
	input  logic signed [47:0] cell_source,
	input  logic [46:0]        freeze_speed,
	input  logic [46:0]        spacing_back,
	input  logic               last_cell,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [47:0] new_value,
	input  logic [9:0]         cell_index,
	input  logic               end_of_grid,
	output int                 fails,
	output int                 pending
);

	localparam longint POS48 = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint NEG48 = -64'sh0000_8000_0000_0000;

	typedef struct {
		logic [47:0] value;
		logic [9:0]  index;
		logic        last;
	} cell_result_t;

	cell_result_t updates_q[$];

	// model copy of the cell windows and the register
	longint      rf_win[4];
	longint      lf_win[4];
	longint      u_dly[3];
	longint      s_dly[3];
	longint      sp_dly[3];
	int          cell_pos;
	logic [31:0] dt;

	function automatic longint clamp48(longint x);
		if (x > POS48)
			return POS48;
		if (x < NEG48)
			return NEG48;
		return x;
	endfunction

	function automatic longint clamp_mag(bit neg, logic [127:0] m);
		logic [127:0] lim;
		lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
		if (m > lim)
			m = lim;
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	// (a*b) >> FRACTION_BITS, rounded half away from zero
	function automatic longint fixed_mul(longint a, logic [63:0] b);
		bit           neg;
		logic [127:0] p;
		neg = a < 0;
		p = 128'(neg ? 64'(-a) : 64'(a)) * 128'(b);
		if (FRACTION_BITS > 0)
			p = (p + (128'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
		return clamp_mag(neg, p);
	endfunction

	// a*b/d, rounded half away from zero
	function automatic longint fixed_muldiv(longint a, logic [63:0] b, logic [63:0] d);
		bit           neg;
		logic [127:0] p, q, r;
		neg = a < 0;
		p = 128'(neg ? 64'(-a) : 64'(a)) * 128'(b);
		q = p / 128'(d);
		r = p % 128'(d);
		if (2 * r >= 128'(d))
			q = q + 1;
		return clamp_mag(neg, q);
	endfunction

	function automatic longint minmod_ll(longint a, longint b);
		if (a > 0 && b > 0)
			return (a < b) ? a : b;
		if (a < 0 && b < 0)
			return (a > b) ? a : b;
		return 0;
	endfunction

	// r0..r3: right flux of cells i-2..i+1; l0..l3: left flux of cells i-1..i+2
	function automatic longint update_cell(longint r0, longint r1, longint r2, longint r3,
		longint l0, longint l1, longint l2, longint l3, bit back_ok, bit fwd_ok,
		longint u, longint s, longint sp);
		longint frp, frm, flp, flm, diff, term, src;
		frp = r2 + minmod_ll(r2 - r1, r3 - r2) / 2;
		flm = l1 + minmod_ll(l0 - l1, l1 - l2) / 2;
		frm = r1;
		if (back_ok)
			frm += minmod_ll(r1 - r0, r2 - r1) / 2;
		flp = l2;
		if (fwd_ok)
			flp += minmod_ll(l1 - l2, l2 - l3) / 2;
		diff = (frp - flp) - (frm - flm);
		if (sp == 0)
			sp = 1;
		term = fixed_muldiv(diff, 64'(dt), 64'(sp));
		src = fixed_mul(s, 64'(dt));
		return clamp48(u - term + src);
	endfunction

	task automatic push_update(longint v, int idx, bit last);
		cell_result_t e;
		e.value = v[47:0];
		e.index = idx[9:0];
		e.last = last;
		updates_q.push_back(e);
	endtask

	task automatic report(string what, logic [47:0] got, logic [47:0] want, logic [9:0] idx);
		$display("mismatch on %s at cell %0d: got %h, expected %h", what, idx, got, want);
		fails++;
	endtask

	// work out the results that one accepted cell releases
	task automatic take_cell();
		longint u, f, s, c, sp, cu, fr, fl, v;
		longint rc[5];
		longint lc[6];
		bit     last;
		int     j;
		u = longint'(cell_value);
		f = longint'(cell_flux);
		s = longint'(cell_source);
		c = longint'({17'd0, freeze_speed});
		sp = longint'({17'd0, spacing_back});
		j = cell_pos;
		last = last_cell || (j >= MAX_CELLS - 1);
		cu = fixed_mul(u, 64'(c));
		fr = (cu + f) / 2;
		fl = (cu - f) / 2;
		for (int k = 0; k < 4; k++) begin
			rc[3 - k] = rf_win[k];
			lc[3 - k] = lf_win[k];
		end
		rc[4] = fr;
		lc[4] = fl;
		lc[5] = 0;

		// cell two back
		if (j >= 2) begin
			v = u_dly[1];
			if (j - 2 != 0)
				v = update_cell(rc[0], rc[1], rc[2], rc[3], lc[1], lc[2], lc[3], lc[4],
					j - 2 >= 2, 1'b1, u_dly[1], s_dly[1], sp_dly[1]);
			push_update(v, j - 2, 1'b0);
		end
		// end of grid flushes the cell before and passes this one
		if (last) begin
			if (j >= 1) begin
				v = u_dly[0];
				if (j - 1 != 0)
					v = update_cell(rc[1], rc[2], rc[3], rc[4], lc[2], lc[3], lc[4], lc[5],
						j - 1 >= 2, 1'b0, u_dly[0], s_dly[0], sp_dly[0]);
				push_update(v, j - 1, 1'b0);
			end
			push_update(u, j, 1'b1);
		end

		for (int k = 3; k > 0; k--) begin
			rf_win[k] = rf_win[k - 1];
			lf_win[k] = lf_win[k - 1];
		end
		rf_win[0] = fr;
		lf_win[0] = fl;
		for (int k = 2; k > 0; k--) begin
			u_dly[k] = u_dly[k - 1];
			s_dly[k] = s_dly[k - 1];
			sp_dly[k] = sp_dly[k - 1];
		end
		u_dly[0] = u;
		s_dly[0] = s;
		sp_dly[0] = sp;
		cell_pos = last ? 0 : j + 1;
	endtask

	initial begin
		fails = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		cell_result_t e;
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				rf_win[k] = 0;
				lf_win[k] = 0;
			end
			for (int k = 0; k < 3; k++) begin
				u_dly[k] = 0;
				s_dly[k] = 0;
				sp_dly[k] = 0;
			end
			cell_pos = 0;
			dt = 32'd65536;
			updates_q.delete();
		end else begin
			// register write
			if (psel && penable && pwrite && pready && paddr == TIME_STEP_ADDR)
				dt = pwdata;
			// input request
			if (in_valid && !in_stall)
				take_cell();
			// result request
			if (out_valid && !out_stall) begin
				if (updates_q.size() == 0) begin
					$display("unexpected result for cell %0d", cell_index);
					fails++;
				end else begin
					e = updates_q.pop_front();
					if (new_value !== e.value)
						report("new_value", new_value, e.value, e.index);
					if (cell_index !== e.index)
						report("cell_index", 48'(cell_index), 48'(e.index), e.index);
					if (end_of_grid !== e.last)
						report("end_of_grid", 48'(end_of_grid), 48'(e.last), e.index);
				end
			end
		end
		pending <= updates_q.size();
	end

endmodule

/* bench/relaxing_tvd_minmod_stencil_top_tb.sv */
`timescale 1ns / 100ps

module relaxing_tvd_minmod_stencil_top_tb;

	localparam logic [2:0] TIME_STEP_ADDR = 3'd0;
	localparam int IDLE_LIMIT = 30000;
	localparam int SETTLE = 700;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [47:0] cell_value = '0;
	logic signed [47:0] cell_flux = '0;
	logic signed [47:0] cell_source = '0;
	logic [46:0]        freeze_speed = '0;
	logic [46:0]        spacing_back = '0;
	logic               last_cell = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [47:0] new_value;
	logic [9:0]         cell_index;
	logic               end_of_grid;

	int  fails;
	int  pending;
	int  cyc = 0;
	bit  calm = 0;
	bit  held = 0;

	relaxing_tvd_minmod_stencil_top dut (.*);

	relaxing_tvd_minmod_stencil_checker #(.TIME_STEP_ADDR(TIME_STEP_ADDR)) chk (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog on accepted requests
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			cyc++;
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("status: fail");
		$finish;
	end

	// receiver stalls, with one long hold while the sender keeps offering
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (!held && cyc > 3000) begin
				out_stall <= 1'b1;
				repeat (4000) @(posedge clk);
				held = 1;
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				n = $urandom_range(0, 99);
				out_stall <= (n >= 50);
				if (n < 50)
					repeat ($urandom_range(1, 60)) @(posedge clk);
				else if (n < 90)
					repeat ($urandom_range(1, 4)) @(posedge clk);
				else
					repeat ($urandom_range(30, 300)) @(posedge clk);
			end
		end
	end

	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(20, 150);
	endfunction

	function automatic logic [47:0] pick48();
		unique case ($urandom_range(0, 11))
			0: return 48'h7FFF_FFFF_FFFF;
			1: return 48'h8000_0000_0000;
			2: return 48'd0;
			3: return 48'hFFFF_FFFF_FFFF;
			4, 5, 6, 7: return 48'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
			default: return 48'({$urandom(), $urandom()});
		endcase
	endfunction

	function automatic logic [46:0] pick47();
		unique case ($urandom_range(0, 11))
			0: return 47'd0;
			1: return 47'h7FFF_FFFF_FFFF;
			2: return 47'd1;
			3, 4, 5, 6, 7: return 47'($urandom_range(1, 1 << 18));
			default: return 47'({$urandom(), $urandom()});
		endcase
	endfunction

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_cell(logic [47:0] u, logic [47:0] f, logic [47:0] s,
		logic [46:0] c, logic [46:0] sp, logic last);
		int g;
		g = sender_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_value <= u;
		cell_flux <= f;
		cell_source <= s;
		freeze_speed <= c;
		spacing_back <= sp;
		last_cell <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// one grid; smooth grids keep the limiter busy, others take wild values
	task automatic send_grid(int len, bit smooth, bit open_end);
		logic [47:0] u, f, base_u, base_f, step_u, step_f;
		base_u = pick48();
		base_f = pick48();
		step_u = 48'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		step_f = 48'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		for (int k = 0; k < len; k++) begin
			u = base_u + 48'(k) * step_u + 48'($urandom_range(0, 4095));
			f = base_f - 48'(k) * step_f + 48'($urandom_range(0, 4095));
			if (smooth)
				send_cell(u, f, 48'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
					47'($urandom_range(0, 1 << 18)), 47'($urandom_range(1 << 12, 1 << 18)),
					!open_end && k == len - 1);
			else
				send_cell(pick48(), pick48(), pick48(), pick47(), pick47(),
					!open_end && k == len - 1);
		end
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		logic [31:0] steps[8];
		int          sent, len, r;
		steps = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd65536, $urandom(), 32'h0000_8000,
			$urandom(), $urandom_range(1, 1 << 20)};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single cell, two cells, extremes, zero spacing and speed
		send_cell(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
			47'h7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF, 1'b1);
		send_cell(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
			47'd0, 47'd1, 1'b0);
		send_cell(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'd0, 47'h7FFF_FFFF_FFFF,
			47'd0, 1'b1);
		send_cell(48'd0, 48'd0, 48'd0, 47'd65536, 47'd0, 1'b0);
		send_cell(48'h0001_0000, 48'hFFFF_0000, 48'h0000_8000, 47'h7FFF_FFFF_FFFF, 47'd0, 1'b0);
		send_cell(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
			47'd65536, 47'd0, 1'b1);
		send_cell(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
			47'd0, 47'd1, 1'b0);
		send_cell(48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000,
			47'd0, 47'd1, 1'b0);
		send_cell(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
			47'h7FFF_FFFF_FFFF, 47'd1, 1'b0);
		send_cell(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
			47'h7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF, 1'b0);
		send_cell(48'd0, 48'd0, 48'd0, 47'd0, 47'd0, 1'b1);
		send_grid(6, 1'b1, 1'b0);
		wait_idle();

		// random phases over the time step settings
		foreach (steps[p]) begin
			apb_write(TIME_STEP_ADDR, steps[p]);
			calm = ($urandom_range(0, 3) == 0);
			sent = 0;
			while (sent < 52) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					len = 1;
				else if (r < 16)
					len = 2;
				else if (r < 22)
					len = $urandom_range(20, 40);
				else
					len = $urandom_range(3, 12);
				send_grid(len, $urandom_range(0, 3) != 0, 1'b0);
				sent += len;
			end
			wait_idle();
		end

		if (fails == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
